@@ hw/rtl/normalized_scaled_jacobian_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the scaled Jacobian quality block
// Clocked property checks with and without a reset qualifier.
// ---------------------------------------------------------------------------
`ifndef NORMALIZED_SCALED_JACOBIAN_ASSERT_SVH
`define NORMALIZED_SCALED_JACOBIAN_ASSERT_SVH
`ifndef SYNTHESIS
`define NSJ_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("normalized_scaled_jacobian: check failed");
`define NSJ_ASSERT_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("normalized_scaled_jacobian: check failed");
`else
`define NSJ_ASSERT(name, clk, rst, prop)
`define NSJ_ASSERT_ALWAYS(name, clk, prop)
`endif
`endif

@@ hw/rtl/nsj_pkg.sv @@
// ---------------------------------------------------------------------------
// nsj_pkg
// Types and fixed constants of the scaled Jacobian quality block.
// ---------------------------------------------------------------------------
package nsj_pkg;

   localparam int QFRAC       = 14;
   localparam int UNIT_BITS   = 20;
   localparam int PROD_BITS   = 3 * UNIT_BITS;
   localparam int ROUND_SHIFT = PROD_BITS - QFRAC;
   localparam int DIV_STEPS   = 52;
   localparam int SQRT_STEPS  = 32;

   localparam logic signed [21:0] QUAL_ONE   = 22'sd1 <<< QFRAC;
   localparam logic signed [15:0] WORST_INIT = 16'sh7FFF;
   localparam logic [32:0]        NORM_HI    = 33'd1 << 30;
   localparam logic [32:0]        NORM_LO    = 33'd1 << 29;
   localparam logic [3:0]         LAST_OP    = 4'd11;
   localparam logic [1:0]         CORNER_TOP = 2'd3;
   localparam logic [1:0]         LAST_VEC   = 2'd2;
   localparam logic [1:0]         LAST_COMP  = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE, ST_DIFF, ST_NORM, ST_SQ_MUL, ST_SQ_ACC, ST_SQRT_GO, ST_SQRT_WAIT,
      ST_DIV_GO, ST_DIV_WAIT, ST_MUL, ST_ACC, ST_ROUND, ST_REMAP, ST_RDIV_GO,
      ST_RDIV_WAIT, ST_FINISH
   } state_type;

   typedef struct packed {
      logic       first;
      logic       sub;
      logic       shift;
      logic       store;
      logic [1:0] cr_sel;
   } op_type;

   function automatic logic signed [15:0] sat16(input logic signed [21:0] v);
      if (v > 22'sd32767) begin
         return 16'sh7FFF;
      end else if (v < -22'sd32768) begin
         return 16'sh8000;
      end
      return v[15:0];
   endfunction

endpackage

@@ hw/rtl/nsj_if.sv @@
// ---------------------------------------------------------------------------
// nsj_req_if / nsj_rsp_if
// Valid/ready channels for corner points and quality results.
// ---------------------------------------------------------------------------
interface nsj_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] coord_x;
   logic signed [31:0] coord_y;
   logic signed [31:0] coord_z;
   logic [1:0]         corner_index;
   logic [14:0]        ideal_ratio;
   logic               element_is_hex;
   logic               last_tetra;
   modport source(output valid, coord_x, coord_y, coord_z, corner_index, ideal_ratio,
                  element_is_hex, last_tetra, input ready);
   modport sink(input valid, coord_x, coord_y, coord_z, corner_index, ideal_ratio,
                element_is_hex, last_tetra, output ready);
endinterface

interface nsj_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] tetra_quality;
   logic signed [15:0] worst_quality;
   logic               element_done;
   modport source(output valid, tetra_quality, worst_quality, element_done, input ready);
   modport sink(input valid, tetra_quality, worst_quality, element_done, output ready);
endinterface

@@ hw/rtl/nsj_div.sv @@
// ---------------------------------------------------------------------------
// nsj_div
// Restoring divider, one quotient bit per cycle; quotient known to fit 21 bits.
// ---------------------------------------------------------------------------
module nsj_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [51:0] num,
   input  logic [31:0] den,
   output logic        done,
   output logic [20:0] quo
);

   logic        busy_ff;
   logic        done_ff;
   logic [5:0]  cnt_ff;
   logic [51:0] num_ff;
   logic [31:0] den_ff;
   logic [31:0] rem_ff;
   logic [20:0] quo_ff;
   logic [32:0] rem2;
   logic        ge;

   assign rem2 = {rem_ff, num_ff[51]};
   assign ge   = rem2 >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 6'd1;
            if (cnt_ff == 6'(nsj_pkg::DIV_STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= num;
         den_ff <= den;
         rem_ff <= '0;
         quo_ff <= '0;
      end else if (busy_ff) begin
         rem_ff <= ge ? 32'(rem2 - {1'b0, den_ff}) : rem2[31:0];
         quo_ff <= {quo_ff[19:0], ge};
         num_ff <= {num_ff[50:0], 1'b0};
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

@@ hw/rtl/nsj_sqrt.sv @@
// ---------------------------------------------------------------------------
// nsj_sqrt
// Integer square root, two radicand bits per cycle.
// ---------------------------------------------------------------------------
module nsj_sqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] num,
   output logic        done,
   output logic [31:0] root
);

   logic        busy_ff;
   logic        done_ff;
   logic [4:0]  cnt_ff;
   logic [63:0] n_ff;
   logic [63:0] res_ff;
   logic [63:0] bit_ff;
   logic [63:0] trial;

   assign trial = res_ff + bit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 5'd1;
            if (cnt_ff == 5'(nsj_pkg::SQRT_STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         n_ff   <= num;
         res_ff <= '0;
         bit_ff <= 64'd1 << 62;
      end else if (busy_ff) begin
         if (n_ff >= trial) begin
            n_ff   <= n_ff - trial;
            res_ff <= (res_ff >> 1) + bit_ff;
         end else begin
            res_ff <= res_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
   end

   assign done = done_ff;
   assign root = res_ff[31:0];

endmodule

@@ hw/rtl/normalized_scaled_jacobian.sv @@
// Corners 0..2 are each stored in the corner registers.
// Corner 3 starts the computation, which runs through the bit-serial divider (nine or ten
// quotients) and the square-root unit (one root per edge), with a normalizing step per
// edge. A zero-length edge skips all of it.
// Synchronous active-high reset clears the sequencer, the output valid and sets the
// running worst quality to 2.0 saturated; corner registers are not cleared.
// ---------------------------------------------------------------------------
// normalized_scaled_jacobian
// Tetra scaled Jacobian quality with remap and per-element running minimum.
// ---------------------------------------------------------------------------
`include "normalized_scaled_jacobian_assert.svh"

module normalized_scaled_jacobian (
   input logic        clock,
   input logic        reset,
   nsj_req_if.sink    req,
   nsj_rsp_if.source  rsp
);

   nsj_pkg::state_type state_ff, state_in;

   logic signed [31:0] held_x_ff [4];
   logic signed [31:0] held_y_ff [4];
   logic signed [31:0] held_z_ff [4];
   logic [14:0]        c_ff;
   logic               hex_ff;
   logic               last_ff;

   logic [1:0]         vec_ff;
   logic [1:0]         comp_ff;
   logic [3:0]         op_cnt_ff;
   logic [32:0]        mag_ff [3];
   logic               neg_ff [3];
   logic [32:0]        m_ff;
   logic [31:0]        len_ff;
   logic signed [21:0] u_ff [3][3];
   logic signed [42:0] cr_ff [3];
   logic signed [65:0] prod_ff;
   logic signed [65:0] acc_ff;
   logic signed [20:0] q_ff;
   logic signed [15:0] qual_ff;
   logic signed [15:0] worst_ff;

   logic               rsp_valid_ff;
   logic signed [15:0] rsp_q_ff;
   logic signed [15:0] rsp_w_ff;
   logic               rsp_d_ff;

   logic               accept;
   logic               fin_go;
   logic [1:0]         idx;
   logic signed [32:0] dif [3];
   logic [32:0]        mag_d [3];
   logic [32:0]        m_d;
   logic signed [32:0] opa, opb;
   logic signed [65:0] mul_p;
   logic signed [65:0] term;
   logic signed [65:0] acc_in;
   nsj_pkg::op_type    op;
   logic               sq_phase;
   logic [65:0]        tmag;
   logic [65:0]        tsum;
   logic [19:0]        rmag;
   logic signed [20:0] q_round;
   logic signed [21:0] q22, c22, r_remap, r_div;
   logic [19:0]        qmag;
   logic               remap_div;
   logic signed [15:0] worst_new;

   logic               sqrt_done;
   logic [31:0]        sqrt_root;
   logic               div_start;
   logic [51:0]        div_num;
   logic [31:0]        div_den;
   logic               div_done;
   logic [20:0]        div_quo;
   logic signed [21:0] uq;

   function automatic logic signed [32:0] sx22(input logic signed [21:0] v);
      return {{11{v[21]}}, v};
   endfunction

   assign accept    = req.valid && req.ready;
   assign req.ready = (state_ff == nsj_pkg::ST_IDLE);
   assign fin_go    = (state_ff == nsj_pkg::ST_FINISH) && (!rsp_valid_ff || rsp.ready);

   // edge vector from apex to corner vec+1
   assign idx = vec_ff + 2'd1;
   assign dif[0] = {held_x_ff[idx][31], held_x_ff[idx]} - {held_x_ff[0][31], held_x_ff[0]};
   assign dif[1] = {held_y_ff[idx][31], held_y_ff[idx]} - {held_y_ff[0][31], held_y_ff[0]};
   assign dif[2] = {held_z_ff[idx][31], held_z_ff[idx]} - {held_z_ff[0][31], held_z_ff[0]};

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mag_d[i] = dif[i][32] ? 33'(-dif[i]) : 33'(dif[i]);
      end
      m_d = mag_d[0];
      if (mag_d[1] > m_d) begin
         m_d = mag_d[1];
      end
      if (mag_d[2] > m_d) begin
         m_d = mag_d[2];
      end
   end

   // shared multiplier operand selection and op table
   assign sq_phase = (state_ff == nsj_pkg::ST_SQ_MUL) || (state_ff == nsj_pkg::ST_SQ_ACC);

   always_comb begin
      opa = signed'(mag_ff[comp_ff]);
      opb = signed'(mag_ff[comp_ff]);
      op  = '{first: (comp_ff == 2'd0), sub: 1'b0, shift: 1'b0, store: 1'b0, cr_sel: 2'd0};
      if (!sq_phase) begin
         unique case (op_cnt_ff)
            4'd0: begin
               opa = sx22(u_ff[0][1]); opb = sx22(u_ff[1][2]);
               op  = '{first: 1'b1, sub: 1'b0, shift: 1'b0, store: 1'b0, cr_sel: 2'd0};
            end
            4'd1: begin
               opa = sx22(u_ff[0][2]); opb = sx22(u_ff[1][1]);
               op  = '{first: 1'b0, sub: 1'b1, shift: 1'b0, store: 1'b1, cr_sel: 2'd0};
            end
            4'd2: begin
               opa = sx22(u_ff[0][2]); opb = sx22(u_ff[1][0]);
               op  = '{first: 1'b1, sub: 1'b0, shift: 1'b0, store: 1'b0, cr_sel: 2'd1};
            end
            4'd3: begin
               opa = sx22(u_ff[0][0]); opb = sx22(u_ff[1][2]);
               op  = '{first: 1'b0, sub: 1'b1, shift: 1'b0, store: 1'b1, cr_sel: 2'd1};
            end
            4'd4: begin
               opa = sx22(u_ff[0][0]); opb = sx22(u_ff[1][1]);
               op  = '{first: 1'b1, sub: 1'b0, shift: 1'b0, store: 1'b0, cr_sel: 2'd2};
            end
            4'd5: begin
               opa = sx22(u_ff[0][1]); opb = sx22(u_ff[1][0]);
               op  = '{first: 1'b0, sub: 1'b1, shift: 1'b0, store: 1'b1, cr_sel: 2'd2};
            end
            // triple product: cross terms split into high and low halves
            4'd6: begin
               opa = sx22(cr_ff[0][42:21]); opb = sx22(u_ff[2][0]);
               op  = '{first: 1'b1, sub: 1'b0, shift: 1'b1, store: 1'b0, cr_sel: 2'd0};
            end
            4'd7: begin
               opa = sx22({1'b0, cr_ff[0][20:0]}); opb = sx22(u_ff[2][0]);
               op  = '{first: 1'b0, sub: 1'b0, shift: 1'b0, store: 1'b0, cr_sel: 2'd0};
            end
            4'd8: begin
               opa = sx22(cr_ff[1][42:21]); opb = sx22(u_ff[2][1]);
               op  = '{first: 1'b0, sub: 1'b0, shift: 1'b1, store: 1'b0, cr_sel: 2'd0};
            end
            4'd9: begin
               opa = sx22({1'b0, cr_ff[1][20:0]}); opb = sx22(u_ff[2][1]);
               op  = '{first: 1'b0, sub: 1'b0, shift: 1'b0, store: 1'b0, cr_sel: 2'd0};
            end
            4'd10: begin
               opa = sx22(cr_ff[2][42:21]); opb = sx22(u_ff[2][2]);
               op  = '{first: 1'b0, sub: 1'b0, shift: 1'b1, store: 1'b0, cr_sel: 2'd0};
            end
            default: begin
               opa = sx22({1'b0, cr_ff[2][20:0]}); opb = sx22(u_ff[2][2]);
               op  = '{first: 1'b0, sub: 1'b0, shift: 1'b0, store: 1'b0, cr_sel: 2'd0};
            end
         endcase
      end
   end

   assign mul_p  = opa * opb;
   assign term   = op.shift ? (prod_ff <<< 21) : prod_ff;
   assign acc_in = (op.first ? 66'sd0 : acc_ff) + (op.sub ? -term : term);

   // round Q60 to quality format, ties away from zero
   assign tmag    = acc_ff[65] ? 66'(-acc_ff) : 66'(acc_ff);
   assign tsum    = tmag + (66'd1 << (nsj_pkg::ROUND_SHIFT - 1));
   assign rmag    = tsum[nsj_pkg::ROUND_SHIFT +: 20];
   assign q_round = acc_ff[65] ? -signed'({1'b0, rmag}) : signed'({1'b0, rmag});

   assign q22  = {q_ff[20], q_ff};
   assign c22  = signed'({7'd0, c_ff});
   assign qmag = q_ff[20] ? 20'(-q_ff) : q_ff[19:0];

   always_comb begin
      remap_div = 1'b0;
      priority if (hex_ff) begin
         r_remap = q22;
      end else if (q22 > c22) begin
         r_remap = nsj_pkg::QUAL_ONE + c22 - q22;
      end else if (q22 < -c22) begin
         r_remap = -nsj_pkg::QUAL_ONE - c22 - q22;
      end else if (c_ff == 15'd0) begin
         r_remap = 22'sd0;
      end else begin
         r_remap   = 22'sd0;
         remap_div = 1'b1;
      end
   end

   assign r_div = q_ff[20] ? -signed'({1'b0, div_quo}) : signed'({1'b0, div_quo});
   assign uq    = signed'({1'b0, div_quo});

   assign div_start = (state_ff == nsj_pkg::ST_DIV_GO) || (state_ff == nsj_pkg::ST_RDIV_GO);
   assign div_num   = (state_ff == nsj_pkg::ST_RDIV_GO)
                      ? (52'(qmag) << nsj_pkg::QFRAC) + 52'(c_ff >> 1)
                      : (52'(mag_ff[comp_ff][29:0]) << nsj_pkg::UNIT_BITS)
                        + 52'(len_ff >> 1);
   assign div_den   = (state_ff == nsj_pkg::ST_RDIV_GO) ? 32'(c_ff) : len_ff;

   assign worst_new = (qual_ff < worst_ff) ? qual_ff : worst_ff;

   nsj_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (state_ff == nsj_pkg::ST_SQRT_GO),
      .num   (acc_ff[63:0]),
      .done  (sqrt_done),
      .root  (sqrt_root)
   );

   nsj_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= nsj_pkg::ST_IDLE;
         worst_ff     <= nsj_pkg::WORST_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (fin_go) begin
            rsp_valid_ff <= 1'b1;
            worst_ff     <= last_ff ? nsj_pkg::WORST_INIT : worst_new;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         nsj_pkg::ST_IDLE: begin
            if (accept && req.corner_index == nsj_pkg::CORNER_TOP) begin
               state_in = nsj_pkg::ST_DIFF;
            end
         end
         nsj_pkg::ST_DIFF: begin
            if (m_d != 33'd0) begin
               state_in = nsj_pkg::ST_NORM;
            end else if (vec_ff == nsj_pkg::LAST_VEC) begin
               state_in = nsj_pkg::ST_MUL;
            end
         end
         nsj_pkg::ST_NORM: begin
            if (m_ff < nsj_pkg::NORM_HI && m_ff >= nsj_pkg::NORM_LO) begin
               state_in = nsj_pkg::ST_SQ_MUL;
            end
         end
         nsj_pkg::ST_SQ_MUL: state_in = nsj_pkg::ST_SQ_ACC;
         nsj_pkg::ST_SQ_ACC: begin
            state_in = (comp_ff == nsj_pkg::LAST_COMP) ? nsj_pkg::ST_SQRT_GO
                                                       : nsj_pkg::ST_SQ_MUL;
         end
         nsj_pkg::ST_SQRT_GO: state_in = nsj_pkg::ST_SQRT_WAIT;
         nsj_pkg::ST_SQRT_WAIT: begin
            if (sqrt_done) begin
               state_in = nsj_pkg::ST_DIV_GO;
            end
         end
         nsj_pkg::ST_DIV_GO: state_in = nsj_pkg::ST_DIV_WAIT;
         nsj_pkg::ST_DIV_WAIT: begin
            if (div_done) begin
               if (comp_ff != nsj_pkg::LAST_COMP) begin
                  state_in = nsj_pkg::ST_DIV_GO;
               end else if (vec_ff == nsj_pkg::LAST_VEC) begin
                  state_in = nsj_pkg::ST_MUL;
               end else begin
                  state_in = nsj_pkg::ST_DIFF;
               end
            end
         end
         nsj_pkg::ST_MUL: state_in = nsj_pkg::ST_ACC;
         nsj_pkg::ST_ACC: begin
            state_in = (op_cnt_ff == nsj_pkg::LAST_OP) ? nsj_pkg::ST_ROUND : nsj_pkg::ST_MUL;
         end
         nsj_pkg::ST_ROUND: state_in = nsj_pkg::ST_REMAP;
         nsj_pkg::ST_REMAP: begin
            state_in = remap_div ? nsj_pkg::ST_RDIV_GO : nsj_pkg::ST_FINISH;
         end
         nsj_pkg::ST_RDIV_GO: state_in = nsj_pkg::ST_RDIV_WAIT;
         nsj_pkg::ST_RDIV_WAIT: begin
            if (div_done) begin
               state_in = nsj_pkg::ST_FINISH;
            end
         end
         nsj_pkg::ST_FINISH: begin
            if (fin_go) begin
               state_in = nsj_pkg::ST_IDLE;
            end
         end
         default: state_in = nsj_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         held_x_ff[req.corner_index] <= req.coord_x;
         held_y_ff[req.corner_index] <= req.coord_y;
         held_z_ff[req.corner_index] <= req.coord_z;
         if (req.corner_index == nsj_pkg::CORNER_TOP) begin
            c_ff    <= req.ideal_ratio;
            hex_ff  <= req.element_is_hex;
            last_ff <= req.last_tetra;
         end
      end
      unique case (state_ff)
         nsj_pkg::ST_IDLE: begin
            vec_ff    <= 2'd0;
            op_cnt_ff <= 4'd0;
         end
         nsj_pkg::ST_DIFF: begin
            for (int i = 0; i < 3; i++) begin
               mag_ff[i] <= mag_d[i];
               neg_ff[i] <= dif[i][32];
            end
            m_ff    <= m_d;
            comp_ff <= 2'd0;
            // zero-length edge gives a zero unit vector
            if (m_d == 33'd0) begin
               for (int i = 0; i < 3; i++) begin
                  u_ff[vec_ff][i] <= 22'sd0;
               end
               vec_ff <= vec_ff + 2'd1;
            end
         end
         nsj_pkg::ST_NORM: begin
            if (m_ff >= nsj_pkg::NORM_HI) begin
               for (int i = 0; i < 3; i++) begin
                  mag_ff[i] <= mag_ff[i] >> 1;
               end
               m_ff <= m_ff >> 1;
            end else if (m_ff < nsj_pkg::NORM_LO) begin
               for (int i = 0; i < 3; i++) begin
                  mag_ff[i] <= mag_ff[i] << 1;
               end
               m_ff <= m_ff << 1;
            end
         end
         nsj_pkg::ST_SQ_MUL: prod_ff <= mul_p;
         nsj_pkg::ST_SQ_ACC: begin
            acc_ff  <= acc_in;
            comp_ff <= (comp_ff == nsj_pkg::LAST_COMP) ? 2'd0 : comp_ff + 2'd1;
         end
         nsj_pkg::ST_SQRT_WAIT: begin
            if (sqrt_done) begin
               len_ff <= sqrt_root;
            end
         end
         nsj_pkg::ST_DIV_WAIT: begin
            if (div_done) begin
               u_ff[vec_ff][comp_ff] <= neg_ff[comp_ff] ? -uq : uq;
               if (comp_ff == nsj_pkg::LAST_COMP) begin
                  comp_ff <= 2'd0;
                  vec_ff  <= vec_ff + 2'd1;
               end else begin
                  comp_ff <= comp_ff + 2'd1;
               end
            end
         end
         nsj_pkg::ST_MUL: prod_ff <= mul_p;
         nsj_pkg::ST_ACC: begin
            acc_ff    <= acc_in;
            op_cnt_ff <= op_cnt_ff + 4'd1;
            if (op.store) begin
               cr_ff[op.cr_sel] <= acc_in[42:0];
            end
         end
         nsj_pkg::ST_ROUND: q_ff <= q_round;
         nsj_pkg::ST_REMAP: qual_ff <= nsj_pkg::sat16(r_remap);
         nsj_pkg::ST_RDIV_WAIT: begin
            if (div_done) begin
               qual_ff <= nsj_pkg::sat16(r_div);
            end
         end
         nsj_pkg::ST_FINISH: begin
            if (fin_go) begin
               rsp_q_ff <= qual_ff;
               rsp_w_ff <= worst_new;
               rsp_d_ff <= last_ff;
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.tetra_quality = rsp_q_ff;
   assign rsp.worst_quality = rsp_w_ff;
   assign rsp.element_done  = rsp_d_ff;

   `NSJ_ASSERT(a_rsp_from_finish, clock, reset, $rose(rsp_valid_ff) |-> $past(state_ff == nsj_pkg::ST_FINISH))
   `NSJ_ASSERT(a_worst_not_above, clock, reset, rsp_valid_ff |-> (rsp_w_ff <= rsp_q_ff))
   `NSJ_ASSERT(a_worst_restart, clock, reset, (fin_go && last_ff) |=> (worst_ff == nsj_pkg::WORST_INIT))
   `NSJ_ASSERT(a_norm_range, clock, reset, (state_ff == nsj_pkg::ST_SQ_MUL) |-> (m_ff < nsj_pkg::NORM_HI && m_ff >= nsj_pkg::NORM_LO))

endmodule
